### rtl/rmfpw_pkg.sv
// Shared types and constants for the rotated monochrome framebuffer block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package rmfpw_pkg;

	localparam int unsigned COORD_W = 11;
	localparam int unsigned INDEX_W = 13;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ROT_W   = 2;

	localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
	localparam logic [2:0]        BIT_TOP   = 3'd7;

	localparam logic CMD_PLOT = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
	localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
	localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
	localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

	// queue between the classifier and the store engine; power of two
	localparam int unsigned QUEUE_DEPTH = 2;

	// classified operation, carried through the queue next to its byte address
	typedef struct packed {
		logic       is_read;
		logic       hit;
		logic       color;
		logic [2:0] bit_pos;
	} op_ctrl_t;

endpackage

`default_nettype wire

### rtl/rmfpw_ifs.sv
// Channel interfaces: pixel request, result and rotation register write.
// Depends on rmfpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rmfpw_req_if;
	import rmfpw_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic                      color;
	logic [INDEX_W-1:0]        byte_index;

	modport source (output valid, cmd, pos_x, pos_y, color, byte_index, input ready);
	modport sink (input valid, cmd, pos_x, pos_y, color, byte_index, output ready);
endinterface

interface rmfpw_rsp_if;
	import rmfpw_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_byte;
	logic              accepted;

	modport source (output valid, read_byte, accepted, input ready);
	modport sink (input valid, read_byte, accepted, output ready);
endinterface

interface rmfpw_cfg_if;
	import rmfpw_pkg::*;
	logic             valid;
	logic             ready;
	logic [ROT_W-1:0] wdata;

	modport source (output valid, wdata, input ready);
	modport sink (input valid, wdata, output ready);
endinterface

`default_nettype wire

### rtl/rmfpw_front.sv
// Front end: rotation register, request acceptance, bounds check and
// rotation mapping into a byte address plus bit position. Depends on rmfpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmfpw_front #(
	parameter int PANEL_WIDTH  = 176,
	parameter int PANEL_HEIGHT = 264,
	parameter int ADDR_W       = 13
) (
	input  wire                       clk,
	input  wire                       arst_n,
	rmfpw_cfg_if.sink                 cfg,
	rmfpw_req_if.sink                 req,
	input  wire                       clear_busy,
	input  wire                       q_full,
	output logic                      q_push,
	output rmfpw_pkg::op_ctrl_t       q_ctrl,
	output logic [ADDR_W-1:0]         q_addr
);
	import rmfpw_pkg::*;

	localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
	localparam int DEPTH     = ROW_BYTES * PANEL_HEIGHT;
	localparam int CMP_W     = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

	localparam logic [COORD_W-1:0] W_LAST = COORD_W'(PANEL_WIDTH - 1);
	localparam logic [COORD_W-1:0] H_LAST = COORD_W'(PANEL_HEIGHT - 1);
	localparam logic [COORD_W:0]   W_SIZE = (COORD_W + 1)'(PANEL_WIDTH);
	localparam logic [COORD_W:0]   H_SIZE = (COORD_W + 1)'(PANEL_HEIGHT);

	logic [ROT_W-1:0]   rotation_q;
	logic               swap;
	logic [COORD_W:0]   log_w;
	logic [COORD_W:0]   log_h;
	logic               plot_hit;
	logic               rd_hit;
	logic [COORD_W-1:0] px;
	logic [COORD_W-1:0] py;
	logic [ADDR_W-1:0]  row_base;
	logic [ADDR_W-1:0]  plot_addr;
	logic               is_read;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= ROT_0;
		end else if (cfg.valid && cfg.ready) begin
			rotation_q <= cfg.wdata;
		end
	end

	always_comb begin
		swap  = (rotation_q == ROT_90) || (rotation_q == ROT_270);
		log_w = swap ? H_SIZE : W_SIZE;
		log_h = swap ? W_SIZE : H_SIZE;
		// sign bit clear means the zero-extended bits equal the value
		plot_hit = !req.pos_x[COORD_W-1] && ({1'b0, req.pos_x} < log_w) &&
			!req.pos_y[COORD_W-1] && ({1'b0, req.pos_y} < log_h);

		case (rotation_q)
			ROT_90: begin
				px = W_LAST - req.pos_y;
				py = req.pos_x;
			end
			ROT_180: begin
				px = W_LAST - req.pos_x;
				py = H_LAST - req.pos_y;
			end
			ROT_270: begin
				px = req.pos_y;
				py = H_LAST - req.pos_x;
			end
			default: begin
				px = req.pos_x;
				py = req.pos_y;
			end
		endcase

		// in-range points stay below the store depth, so truncation is exact
		row_base  = ADDR_W'(py) * ADDR_W'(ROW_BYTES);
		plot_addr = row_base + ADDR_W'(px >> 3);

		rd_hit  = CMP_W'(req.byte_index) < CMP_W'(DEPTH);
		is_read = (req.cmd == CMD_READ);

		q_ctrl.is_read = is_read;
		q_ctrl.hit     = is_read ? rd_hit : plot_hit;
		q_ctrl.color   = req.color;
		q_ctrl.bit_pos = BIT_TOP - px[2:0];
		q_addr         = is_read ? ADDR_W'(req.byte_index) : plot_addr;
	end

	assign req.ready = !clear_busy && !q_full;
	assign q_push    = req.valid && req.ready;

endmodule

`default_nettype wire

### rtl/rmfpw_fifo.sv
// Short queue of classified operations between front end and store engine.
// Depends on rmfpw_pkg for the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module rmfpw_fifo #(
	parameter int WIDTH = 19
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire [WIDTH-1:0]  din,
	input  wire              pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);
	import rmfpw_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= din;
	end

	assign dout  = slot_q[rd_ptr_q];
	assign full  = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

endmodule

`default_nettype wire

### rtl/rmfpw_back.sv
// Store engine: byte memory, clearing pass after reset, read-modify-write
// of one pixel bit or byte readback, and the result register. Depends on rmfpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmfpw_back #(
	parameter int PANEL_WIDTH  = 176,
	parameter int PANEL_HEIGHT = 264,
	parameter int ADDR_W       = 13
) (
	input  wire                       clk,
	input  wire                       arst_n,
	rmfpw_rsp_if.source               rsp,
	input  wire                       q_empty,
	input  rmfpw_pkg::op_ctrl_t       q_ctrl,
	input  wire [ADDR_W-1:0]          q_addr,
	output logic                      q_pop,
	output logic                      clear_busy
);
	import rmfpw_pkg::*;

	localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
	localparam int DEPTH     = ROW_BYTES * PANEL_HEIGHT;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_q;

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	op_ctrl_t          op_q;
	logic [ADDR_W-1:0] op_addr_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] read_byte_q;
	logic              accepted_q;

	logic              out_free;
	logic [BYTE_W-1:0] bit_mask;
	logic [BYTE_W-1:0] new_byte;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;

	assign clear_busy = (state_q == ST_CLEAR);
	// result register is empty when the write step lands, or drains that cycle
	assign out_free   = !out_valid_q || rsp.ready;
	assign q_pop      = (state_q == ST_IDLE) && !q_empty && out_free;

	always_comb begin
		bit_mask  = {{(BYTE_W - 1){1'b0}}, 1'b1} << op_q.bit_pos;
		new_byte  = op_q.color ? (rd_q & (BYTE_ONES ^ bit_mask)) : (rd_q | bit_mask);
		mem_we    = clear_busy || ((state_q == ST_WRITE) && op_q.hit && !op_q.is_read);
		mem_waddr = clear_busy ? clr_q : op_addr_q;
		mem_wdata = clear_busy ? '0 : new_byte;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (q_pop) rd_q <= mem[q_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_pop) state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (state_q == ST_WRITE) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q      <= q_ctrl;
			op_addr_q <= q_addr;
		end
		if (state_q == ST_WRITE) begin
			read_byte_q <= (op_q.is_read && op_q.hit) ? rd_q : '0;
			accepted_q  <= op_q.hit;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_byte = read_byte_q;
	assign rsp.accepted  = accepted_q;

endmodule

`default_nettype wire

### rtl/rotated_mono_framebuffer_pixel_write.sv
// Top level of the rotated one-bit-per-pixel framebuffer.
// Depends on rmfpw_pkg, rmfpw_ifs, rmfpw_front, rmfpw_fifo, rmfpw_back.
//
// Usage:
//   cfg : rotation register write (quarter turns), always ready. Write only
//         while no request is in flight.
//   req : plot a pixel (cmd 0) or read back a stored byte (cmd 1). A
//         transaction completes when valid and ready are both high.
//   rsp : one result per request, in order: read_byte and accepted.
//   Path: a request goes through the queue to the store engine, whose
//   read-modify-write of the byte memory (registered read, then write of
//   the modified byte) also loads the result register. The engine pops the
//   next request only after its write step; the queue takes requests meanwhile.
//   Reset: the store is swept to zero one byte per cycle, all ROW_BYTES *
//   PANEL_HEIGHT bytes (5808 at the default size); req.ready stays low
//   during the sweep. Rotation resets to 0.
//   Receiver stall: the result register holds, the store engine stops
//   taking work, the two-entry queue fills and req.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module rotated_mono_framebuffer_pixel_write #(
	parameter int PANEL_WIDTH  = 176,
	parameter int PANEL_HEIGHT = 264
) (
	input  wire         clk,
	input  wire         arst_n,
	rmfpw_cfg_if.sink   cfg,
	rmfpw_req_if.sink   req,
	rmfpw_rsp_if.source rsp
);
	import rmfpw_pkg::*;

	localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
	localparam int DEPTH     = ROW_BYTES * PANEL_HEIGHT;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int Q_W       = $bits(op_ctrl_t) + ADDR_W;

	logic              clear_busy;
	logic              q_full;
	logic              q_empty;
	logic              q_push;
	logic              q_pop;
	op_ctrl_t          push_ctrl;
	logic [ADDR_W-1:0] push_addr;
	op_ctrl_t          pop_ctrl;
	logic [ADDR_W-1:0] pop_addr;
	logic [Q_W-1:0]    q_dout;

	rmfpw_front #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT),
		.ADDR_W       (ADDR_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req        (req),
		.clear_busy (clear_busy),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_ctrl     (push_ctrl),
		.q_addr     (push_addr)
	);

	rmfpw_fifo #(
		.WIDTH (Q_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    ({push_ctrl, push_addr}),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {pop_ctrl, pop_addr} = q_dout;

	rmfpw_back #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT),
		.ADDR_W       (ADDR_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rsp        (rsp),
		.q_empty    (q_empty),
		.q_ctrl     (pop_ctrl),
		.q_addr     (pop_addr),
		.q_pop      (q_pop),
		.clear_busy (clear_busy)
	);

endmodule

`default_nettype wire

### rtl/rmfpw_checker.sv
// Port-level assertions for the framebuffer top level, attached by bind.
// Depends on rmfpw_pkg and rotated_mono_framebuffer_pixel_write.
`timescale 1ns / 1ps
`default_nettype none

module rmfpw_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        req_valid,
	input wire                        req_ready,
	input wire                        rsp_valid,
	input wire                        rsp_ready,
	input wire [rmfpw_pkg::BYTE_W-1:0] rsp_read_byte,
	input wire                        rsp_accepted
);
	import rmfpw_pkg::*;

	logic       req_xfer;
	logic       rsp_xfer;
	logic [2:0] pending_q;

	assign req_xfer = req_valid && req_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	// requests taken minus results delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {2'b00, req_xfer} - {2'b00, rsp_xfer};
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			rsp_valid && $stable(rsp_read_byte) && $stable(rsp_accepted))
		else $error("result changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 3'd0)
		else $error("result without an outstanding request");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_accepted |-> rsp_read_byte == '0)
		else $error("dropped request returned nonzero data");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && pending_q == 3'd0 |=> !rsp_valid)
		else $error("result appeared one cycle after request into empty block");

endmodule

bind rotated_mono_framebuffer_pixel_write rmfpw_checker u_rmfpw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_byte (rsp.read_byte),
	.rsp_accepted  (rsp.accepted)
);

`default_nettype wire

### test/framebuffer_shadow_check.sv
// Checker for the rotated monochrome framebuffer: keeps a shadow copy of the
// pixel store and the rotation register and checks every result in order.
// Depends on rmfpw_pkg and rmfpw_ifs.
`timescale 1ns / 1ps

module framebuffer_shadow_check
	import rmfpw_pkg::*;
#(
	parameter int PANEL_WIDTH  = 176,
	parameter int PANEL_HEIGHT = 264
) (
	input  logic        clk,
	input  logic        arst_n,
	rmfpw_cfg_if        cfg,
	rmfpw_req_if        req,
	rmfpw_rsp_if        rsp,
	output int unsigned mismatches,
	output int unsigned in_flight
);

	localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
	localparam int STORE_DEPTH = ROW_BYTES * PANEL_HEIGHT;

	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		logic              accepted;
	} pixel_result_t;

	logic [BYTE_W-1:0] shadow_store [STORE_DEPTH];
	logic [ROT_W-1:0]  shadow_turns;
	pixel_result_t     owed_results [$];

	// updates the shadow store for a plot and returns the result the block owes
	function automatic pixel_result_t apply_pixel_op(
		input logic                      op,
		input logic signed [COORD_W-1:0] x_in,
		input logic signed [COORD_W-1:0] y_in,
		input logic                      color,
		input logic [INDEX_W-1:0]        index
	);
		pixel_result_t     res;
		int                x, y, lw, lh, px, py, addr;
		logic [BYTE_W-1:0] mask;
		res = '0;
		x = int'(x_in);
		y = int'(y_in);
		if (op == CMD_READ) begin
			if (int'(index) < STORE_DEPTH) begin
				res.read_byte = shadow_store[index];
				res.accepted  = 1'b1;
			end
			return res;
		end
		if (shadow_turns == ROT_90 || shadow_turns == ROT_270) begin
			lw = PANEL_HEIGHT;
			lh = PANEL_WIDTH;
		end else begin
			lw = PANEL_WIDTH;
			lh = PANEL_HEIGHT;
		end
		// off the logical panel: dropped, store untouched
		if (x < 0 || x >= lw || y < 0 || y >= lh)
			return res;
		case (shadow_turns)
			ROT_90: begin
				px = PANEL_WIDTH - 1 - y;
				py = x;
			end
			ROT_180: begin
				px = PANEL_WIDTH - 1 - x;
				py = PANEL_HEIGHT - 1 - y;
			end
			ROT_270: begin
				px = y;
				py = PANEL_HEIGHT - 1 - x;
			end
			default: begin
				px = x;
				py = y;
			end
		endcase
		addr = py * ROW_BYTES + px / BYTE_W;
		mask = BYTE_W'(1) << (BIT_TOP - px[2:0]);
		// color 1 clears the bit, color 0 sets it
		if (color)
			shadow_store[addr] = shadow_store[addr] & (BYTE_ONES ^ mask);
		else
			shadow_store[addr] = shadow_store[addr] | mask;
		res.accepted = 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t want;
		if (!arst_n) begin
			foreach (shadow_store[i])
				shadow_store[i] = '0;
			shadow_turns = ROT_0;
			owed_results.delete();
			mismatches = 0;
		end else begin
			// results first: a result in the same cycle as a request is an older one
			if (rsp.valid && rsp.ready) begin
				if (owed_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing owed: read_byte %02h accepted %0b",
						$time, rsp.read_byte, rsp.accepted);
				end else begin
					want = owed_results.pop_front();
					if (rsp.read_byte !== want.read_byte) begin
						mismatches++;
						$display("%0t: read_byte expected %02h, got %02h",
							$time, want.read_byte, rsp.read_byte);
					end
					if (rsp.accepted !== want.accepted) begin
						mismatches++;
						$display("%0t: accepted expected %0b, got %0b",
							$time, want.accepted, rsp.accepted);
					end
				end
			end
			if (cfg.valid && cfg.ready)
				shadow_turns = cfg.wdata;
			if (req.valid && req.ready)
				owed_results.push_back(apply_pixel_op(req.cmd, req.pos_x, req.pos_y,
					req.color, req.byte_index));
		end
		in_flight = owed_results.size();
	end

endmodule

### test/rotated_mono_framebuffer_pixel_write_test.sv
// Testbench top for the rotated monochrome framebuffer: drives plot and read
// transactions under all four rotations and gives the verdict.
// Depends on rmfpw_pkg, rmfpw_ifs, framebuffer_shadow_check and the block itself.
`timescale 1ns / 1ps

module rotated_mono_framebuffer_pixel_write_test;
	import rmfpw_pkg::*;

	localparam int PANEL_WIDTH  = 176;
	localparam int PANEL_HEIGHT = 264;
	localparam int ROW_BYTES    = (PANEL_WIDTH + 7) / 8;
	localparam int STORE_DEPTH  = ROW_BYTES * PANEL_HEIGHT;
	// reset sweep of all STORE_DEPTH bytes passes with no transfers
	localparam int QUIET_LIMIT  = 4 * STORE_DEPTH;
	localparam int PHASE_ITEMS  = 175;
	localparam int PHASES       = 6;

	localparam logic INK_SET   = 1'b0;
	localparam logic INK_CLEAR = 1'b1;

	localparam logic [ROT_W-1:0] TURN_PLAN [PHASES] =
		'{ROT_270, ROT_90, ROT_180, ROT_0, ROT_270, ROT_90};

	logic        clk;
	logic        arst_n;
	logic        calm;
	int unsigned mismatches;
	int unsigned in_flight;
	int unsigned quiet_cycles = 0;
	int          plot_count;
	int          read_count;
	logic [ROT_W-1:0] cur_turns;

	rmfpw_cfg_if cfg ();
	rmfpw_req_if req ();
	rmfpw_rsp_if rsp ();

	rotated_mono_framebuffer_pixel_write #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.req   (req),
		.rsp   (rsp)
	);

	framebuffer_shadow_check #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.rsp       (rsp),
		.mismatches(mismatches),
		.in_flight (in_flight)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(negedge clk) begin
		rsp.ready <= calm || ($urandom_range(99) >= 23);
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_pixel_op(input logic op, input int x, input int y,
		input logic color, input int index);
		req.valid      <= 1'b1;
		req.cmd        <= op;
		req.pos_x      <= COORD_W'(x);
		req.pos_y      <= COORD_W'(y);
		req.color      <= color;
		req.byte_index <= INDEX_W'(index);
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		if (op == CMD_READ)
			read_count++;
		else
			plot_count++;
	endtask

	task automatic maybe_pause();
		if (!calm && $urandom_range(99) < 23) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	// hold off the sender until the block has handed back everything
	task automatic wait_for_results();
		req.valid <= 1'b0;
		while (in_flight != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_rotation(input logic [ROT_W-1:0] turns);
		cfg.valid <= 1'b1;
		cfg.wdata <= turns;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		cur_turns = turns;
	endtask

	// mostly plots landing near the panel center (same physical bytes for every
	// rotation) and reads of those bytes, plus noise off the panel and store
	task automatic send_random_op();
		int   lw, lh, pick, x, y, index;
		logic color;
		if (cur_turns == ROT_90 || cur_turns == ROT_270) begin
			lw = PANEL_HEIGHT;
			lh = PANEL_WIDTH;
		end else begin
			lw = PANEL_WIDTH;
			lh = PANEL_HEIGHT;
		end
		x     = int'($urandom);
		y     = int'($urandom);
		index = int'($urandom);
		color = 1'($urandom);
		pick  = $urandom_range(99);
		if (pick < 40) begin
			x = lw / 2 - 8 + int'($urandom_range(15));
			y = lh / 2 - 8 + int'($urandom_range(15));
			send_pixel_op(CMD_PLOT, x, y, color, index);
		end else if (pick < 55) begin
			x = int'($urandom_range(lw - 1));
			y = int'($urandom_range(lh - 1));
			send_pixel_op(CMD_PLOT, x, y, color, index);
		end else if (pick < 80) begin
			index = (123 + int'($urandom_range(17))) * ROW_BYTES + 9 + int'($urandom_range(3));
			send_pixel_op(CMD_READ, x, y, color, index);
		end else if (pick < 85) begin
			index = int'($urandom_range(STORE_DEPTH - 1));
			send_pixel_op(CMD_READ, x, y, color, index);
		end else if (pick < 95) begin
			send_pixel_op(CMD_PLOT, x, y, color, index);
		end else begin
			index = int'($urandom_range(STORE_DEPTH, (1 << INDEX_W) - 1));
			send_pixel_op(CMD_READ, x, y, color, index);
		end
	endtask

	initial begin
		calm           = 1'b0;
		arst_n         = 1'b0;
		plot_count     = 0;
		read_count     = 0;
		cur_turns      = ROT_0;
		req.valid      = 1'b0;
		req.cmd        = CMD_PLOT;
		req.pos_x      = '0;
		req.pos_y      = '0;
		req.color      = INK_SET;
		req.byte_index = '0;
		cfg.valid      = 1'b0;
		cfg.wdata      = ROT_0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_rotation(ROT_0);
		send_pixel_op(CMD_READ, 0, 0, INK_SET, 0);
		send_pixel_op(CMD_PLOT, 0, 0, INK_SET, 0);
		send_pixel_op(CMD_READ, 0, 0, INK_SET, 0);
		send_pixel_op(CMD_PLOT, 7, 0, INK_SET, 0);
		send_pixel_op(CMD_PLOT, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, INK_SET, 0);
		send_pixel_op(CMD_READ, 0, 0, INK_SET, STORE_DEPTH - 1);
		send_pixel_op(CMD_PLOT, 0, 0, INK_CLEAR, 0);
		send_pixel_op(CMD_READ, 0, 0, INK_SET, 0);
		// off-panel plots: negative, exactly one past the edge, field extremes
		send_pixel_op(CMD_PLOT, -1, 0, INK_SET, 0);
		send_pixel_op(CMD_PLOT, 0, -1, INK_SET, 0);
		send_pixel_op(CMD_PLOT, PANEL_WIDTH, 0, INK_SET, 0);
		send_pixel_op(CMD_PLOT, 0, PANEL_HEIGHT, INK_SET, 0);
		send_pixel_op(CMD_PLOT, -1024, -1024, INK_SET, 0);
		send_pixel_op(CMD_PLOT, 1023, 1023, INK_CLEAR, 0);
		// reads past the end of the store
		send_pixel_op(CMD_READ, 0, 0, INK_SET, STORE_DEPTH);
		send_pixel_op(CMD_READ, -1, -1, INK_CLEAR, (1 << INDEX_W) - 1);
		// back-to-back hits on one byte exercise the read-modify-write ordering
		send_pixel_op(CMD_PLOT, 1, 0, INK_SET, 0);
		send_pixel_op(CMD_PLOT, 1, 0, INK_CLEAR, 0);
		send_pixel_op(CMD_PLOT, 2, 0, INK_SET, 0);
		send_pixel_op(CMD_READ, 0, 0, INK_SET, 0);
		send_pixel_op(CMD_READ, 0, 0, INK_SET, STORE_DEPTH - 1);
		wait_for_results();

		for (int p = 0; p < PHASES; p++) begin
			set_rotation(TURN_PLAN[p]);
			calm = (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 4 && n == PHASE_ITEMS / 2)
					wait_for_results();
				maybe_pause();
				send_random_op();
			end
			wait_for_results();
		end

		$display("Covered %0d plots and %0d byte reads across all four rotations,",
			plot_count, read_count);
		$display("with off-panel plots, out-of-store reads and same-byte bursts.");
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/rmfpw_pkg.sv
rtl/rmfpw_ifs.sv
rtl/rmfpw_front.sv
rtl/rmfpw_fifo.sv
rtl/rmfpw_back.sv
rtl/rotated_mono_framebuffer_pixel_write.sv
rtl/rmfpw_checker.sv
test/framebuffer_shadow_check.sv
test/rotated_mono_framebuffer_pixel_write_test.sv
